>>> rtl/point_in_polygon_classifier_unit_defines.svh
// assertion macros for the classifier unit
`ifndef POINT_IN_POLYGON_CLASSIFIER_UNIT_DEFINES_SVH
`define POINT_IN_POLYGON_CLASSIFIER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off while in reset
`define PIPC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pipc assertion failed");

// next-cycle implication, sampled on clk_i, off while in reset
`define PIPC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pipc assertion failed");

`endif

>>> rtl/pipc_pkg.sv
`default_nettype none
package pipc_pkg;

  localparam int unsigned CoordWidth = 16;
  localparam int unsigned DiffWidth  = CoordWidth + 1;
  localparam int unsigned ProdWidth  = 2 * DiffWidth;
  localparam int unsigned CmpWidth   = ProdWidth + 1;

  typedef logic signed [CoordWidth-1:0] coord_t;
  typedef logic signed [DiffWidth-1:0]  diff_t;

  typedef enum logic {
    OpLoadQuery = 1'b0,
    OpVertex    = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    LocOutside  = 2'd0,
    LocInside   = 2'd1,
    LocBoundary = 2'd2
  } location_e;

  // sign of a*b - c*d
  typedef struct packed {
    logic neg;
    logic zero;
  } sign_t;

  typedef struct packed {
    logic on_boundary;
    logic crosses;
  } edge_res_t;

endpackage
`default_nettype wire

>>> rtl/point_in_polygon_classifier_unit.sv
// point-in-polygon classifier, ray casting with exact integer edge tests
//
// input channel (in_valid_i / in_stall_o): operation_i, coord_x_i, coord_y_i,
// last_vertex_i. a query-load beat sets the point and clears the polygon; each
// vertex beat tests the edge from the previous vertex, and a vertex beat with
// last_vertex_i also tests the closing edge to the first vertex and emits one
// location_o beat (0 outside, 1 inside, 2 on the boundary).
// output channel (out_valid_o / out_stall_i): location_o.
//
// a beat lands in the input register, and from there both edge tests run
// combinationally into the state and result registers; a result is offered
// from the result register. one beat per cycle is sustained unless a final
// vertex waits on the output; the rate is set by the two combinational edge checkers (eight 17x17 products).
// while a result sits stalled in the output register, query and non-final
// vertex beats keep flowing; only a final vertex waits for the output slot.
// reset clears the query point, the polygon state and both valid flags.
`default_nettype none
module point_in_polygon_classifier_unit
  import pipc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       operation_i,
  input  coord_t     coord_x_i,
  input  coord_t     coord_y_i,
  input  logic       last_vertex_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] location_o
);

`include "point_in_polygon_classifier_unit_defines.svh"

  logic      in_valid_q;
  op_e       in_op_q;
  coord_t    in_x_q, in_y_q;
  logic      in_last_q;

  coord_t    query_x_q, query_x_d, query_y_q, query_y_d;
  coord_t    first_x_q, first_x_d, first_y_q, first_y_d;
  coord_t    prev_x_q, prev_x_d, prev_y_q, prev_y_d;
  logic      have_q, have_d, par_q, par_d, bnd_q, bnd_d;

  logic      out_valid_q, out_valid_d;
  location_e location_q;

  logic      is_vertex, emits, out_free, fire, in_load;
  coord_t    close_x, close_y;
  edge_res_t res_step, res_close;
  logic      par_fin, bnd_fin;

  assign is_vertex  = (in_op_q == OpVertex);
  assign emits      = is_vertex && in_last_q;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && (!emits || out_free);
  assign in_stall_o = in_valid_q && !fire;
  assign in_load    = in_valid_i && !in_stall_o;

  assign close_x = have_q ? first_x_q : in_x_q;
  assign close_y = have_q ? first_y_q : in_y_q;

  pipc_edge_check u_step (
    .xj_i  (prev_x_q),
    .yj_i  (prev_y_q),
    .xk_i  (in_x_q),
    .yk_i  (in_y_q),
    .qx_i  (query_x_q),
    .qy_i  (query_y_q),
    .res_o (res_step)
  );

  pipc_edge_check u_close (
    .xj_i  (in_x_q),
    .yj_i  (in_y_q),
    .xk_i  (close_x),
    .yk_i  (close_y),
    .qx_i  (query_x_q),
    .qy_i  (query_y_q),
    .res_o (res_close)
  );

  assign par_fin = par_q ^ (have_q & res_step.crosses) ^ res_close.crosses;
  assign bnd_fin = bnd_q | (have_q & res_step.on_boundary) | res_close.on_boundary;

  always_comb begin
    query_x_d = query_x_q;
    query_y_d = query_y_q;
    first_x_d = first_x_q;
    first_y_d = first_y_q;
    prev_x_d  = prev_x_q;
    prev_y_d  = prev_y_q;
    have_d    = have_q;
    par_d     = par_q;
    bnd_d     = bnd_q;
    if (fire) begin
      if (!is_vertex) begin
        query_x_d = in_x_q;
        query_y_d = in_y_q;
        have_d    = 1'b0;
        par_d     = 1'b0;
        bnd_d     = 1'b0;
      end else begin
        if (!have_q) begin
          first_x_d = in_x_q;
          first_y_d = in_y_q;
        end
        prev_x_d = in_x_q;
        prev_y_d = in_y_q;
        if (in_last_q) begin
          have_d = 1'b0;
          par_d  = 1'b0;
          bnd_d  = 1'b0;
        end else begin
          have_d = 1'b1;
          par_d  = par_q ^ (have_q & res_step.crosses);
          bnd_d  = bnd_q | (have_q & res_step.on_boundary);
        end
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (fire && emits) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      query_x_q   <= '0;
      query_y_q   <= '0;
      first_x_q   <= '0;
      first_y_q   <= '0;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      have_q      <= 1'b0;
      par_q       <= 1'b0;
      bnd_q       <= 1'b0;
    end else begin
      if (in_load) begin
        in_valid_q <= 1'b1;
      end else if (fire) begin
        in_valid_q <= 1'b0;
      end
      out_valid_q <= out_valid_d;
      query_x_q   <= query_x_d;
      query_y_q   <= query_y_d;
      first_x_q   <= first_x_d;
      first_y_q   <= first_y_d;
      prev_x_q    <= prev_x_d;
      prev_y_q    <= prev_y_d;
      have_q      <= have_d;
      par_q       <= par_d;
      bnd_q       <= bnd_d;
    end
  end

  // input beat and result payloads
  always_ff @(posedge clk_i) begin
    if (in_load) begin
      in_op_q   <= op_e'(operation_i);
      in_x_q    <= coord_x_i;
      in_y_q    <= coord_y_i;
      in_last_q <= last_vertex_i;
    end
    if (fire && emits) begin
      location_q <= bnd_fin ? LocBoundary : (par_fin ? LocInside : LocOutside);
    end
  end

  assign out_valid_o = out_valid_q;
  assign location_o  = location_q;

  `PIPC_ASSERT_NOW(a_stall_only_on_full_output, in_valid_q && !fire,
    emits && out_valid_q && out_stall_i)
  `PIPC_ASSERT_NEXT(a_final_vertex_gives_result, fire && emits, out_valid_o)
  `PIPC_ASSERT_NEXT(a_query_clears_polygon, fire && !is_vertex,
    !have_q && !par_q && !bnd_q)
  `PIPC_ASSERT_NEXT(a_result_restarts_polygon, fire && emits, !have_q && !par_q && !bnd_q)

endmodule
`default_nettype wire

>>> rtl/pipc_prod_sign.sv
`default_nettype none
module pipc_prod_sign
  import pipc_pkg::*;
(
  input  diff_t a_i,
  input  diff_t b_i,
  input  diff_t c_i,
  input  diff_t d_i,
  output sign_t sign_o
);

  logic signed [ProdWidth-1:0] prod_ab;
  logic signed [ProdWidth-1:0] prod_cd;
  logic signed [CmpWidth-1:0]  delta;

  assign prod_ab = a_i * b_i;
  assign prod_cd = c_i * d_i;
  assign delta   = CmpWidth'(prod_ab) - CmpWidth'(prod_cd);

  assign sign_o.neg  = delta[CmpWidth-1];
  assign sign_o.zero = (delta == '0);

endmodule
`default_nettype wire

>>> rtl/pipc_edge_check.sv
`default_nettype none
module pipc_edge_check
  import pipc_pkg::*;
(
  input  coord_t    xj_i,
  input  coord_t    yj_i,
  input  coord_t    xk_i,
  input  coord_t    yk_i,
  input  coord_t    qx_i,
  input  coord_t    qy_i,
  output edge_res_t res_o
);

  diff_t dxjq, dykq, dxkq, dyjq;
  diff_t qy_yj, xk_xj, qx_xj, yk_yj;
  sign_t col_sign;
  sign_t cross_sign;
  logic  in_box;
  logic  collinear;
  logic  straddle;
  logic  cross_pos;

  // offsets from the query point
  assign dxjq = DiffWidth'(xj_i) - DiffWidth'(qx_i);
  assign dykq = DiffWidth'(yk_i) - DiffWidth'(qy_i);
  assign dxkq = DiffWidth'(xk_i) - DiffWidth'(qx_i);
  assign dyjq = DiffWidth'(yj_i) - DiffWidth'(qy_i);

  // offsets from the edge start
  assign qy_yj = DiffWidth'(qy_i) - DiffWidth'(yj_i);
  assign xk_xj = DiffWidth'(xk_i) - DiffWidth'(xj_i);
  assign qx_xj = DiffWidth'(qx_i) - DiffWidth'(xj_i);
  assign yk_yj = DiffWidth'(yk_i) - DiffWidth'(yj_i);

  pipc_prod_sign u_col (
    .a_i    (dxjq),
    .b_i    (dykq),
    .c_i    (dxkq),
    .d_i    (dyjq),
    .sign_o (col_sign)
  );

  pipc_prod_sign u_cross (
    .a_i    (qy_yj),
    .b_i    (xk_xj),
    .c_i    (qx_xj),
    .d_i    (yk_yj),
    .sign_o (cross_sign)
  );

  assign in_box = ((xj_i <= qx_i && qx_i <= xk_i) || (xj_i >= qx_i && qx_i >= xk_i)) &&
                  ((yj_i <= qy_i && qy_i <= yk_i) || (yj_i >= qy_i && qy_i >= yk_i));
  assign collinear = col_sign.zero;

  assign straddle  = (yj_i < qy_i && yk_i >= qy_i) || (yj_i > qy_i && yk_i <= qy_i);
  assign cross_pos = !cross_sign.neg && !cross_sign.zero;

  assign res_o.on_boundary = collinear && in_box;
  assign res_o.crosses     = !(collinear && in_box) && straddle &&
                             ((yk_i > yj_i && cross_sign.neg) || (yk_i < yj_i && cross_pos));

endmodule
`default_nettype wire

>>> tb/pip_location_checker.sv
`timescale 1ns / 1ps
module pip_location_checker
  import pipc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic       operation_i,
  input  coord_t     coord_x_i,
  input  coord_t     coord_y_i,
  input  logic       last_vertex_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [1:0] location_i,
  output int         errors_o,
  output int         pending_o
);

  coord_t    qry_x, qry_y, first_x, first_y, prev_x, prev_y;
  logic      have_first, parity, on_edge;
  location_e pending_locations[$];
  int        errors;

  // sign of a*b - c*d, exact since the differences stay within 17 bits
  function automatic int sign_of_diff(longint a, longint b, longint c, longint d);
    longint r;
    r = a * b - c * d;
    return (r > 0) ? 1 : ((r < 0) ? -1 : 0);
  endfunction

  function automatic bit within_span(longint a, longint v, longint b);
    return (a <= v && v <= b) || (a >= v && v >= b);
  endfunction

  function automatic void test_edge(longint xj, longint yj, longint xk, longint yk);
    longint qx, qy, dy;
    int     c;
    qx = qry_x;
    qy = qry_y;
    if (sign_of_diff(xj - qx, yk - qy, xk - qx, yj - qy) == 0 &&
        within_span(xj, qx, xk) && within_span(yj, qy, yk)) begin
      on_edge = 1'b1;
      return;
    end
    // horizontal edges never satisfy the straddle test
    if ((yj < qy && yk >= qy) || (yj > qy && yk <= qy)) begin
      dy = yk - yj;
      c  = sign_of_diff(qy - yj, xk - xj, qx - xj, dy);
      if ((dy > 0 && c < 0) || (dy < 0 && c > 0)) parity = !parity;
    end
  endfunction

  function automatic void take_beat(logic op, coord_t x, coord_t y, logic last);
    if (op == OpLoadQuery) begin
      qry_x      = x;
      qry_y      = y;
      have_first = 1'b0;
      parity     = 1'b0;
      on_edge    = 1'b0;
      return;
    end
    if (!have_first) begin
      first_x    = x;
      first_y    = y;
      have_first = 1'b1;
    end else begin
      test_edge(prev_x, prev_y, x, y);
    end
    prev_x = x;
    prev_y = y;
    if (last) begin
      test_edge(x, y, first_x, first_y);
      pending_locations.push_back(on_edge ? LocBoundary : (parity ? LocInside : LocOutside));
      have_first = 1'b0;
      parity     = 1'b0;
      on_edge    = 1'b0;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qry_x      = '0;
      qry_y      = '0;
      first_x    = '0;
      first_y    = '0;
      prev_x     = '0;
      prev_y     = '0;
      have_first = 1'b0;
      parity     = 1'b0;
      on_edge    = 1'b0;
      pending_locations.delete();
      errors     = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (pending_locations.size() == 0) begin
          $display("%0t: unexpected location beat, expected none, got %0d",
                   $time, location_i);
          errors++;
        end else begin
          if (location_i !== pending_locations[0]) begin
            $display("%0t: location mismatch, expected %0d, got %0d",
                     $time, pending_locations[0], location_i);
            errors++;
          end
          void'(pending_locations.pop_front());
        end
      end
      if (in_valid_i && !in_stall_i)
        take_beat(operation_i, coord_x_i, coord_y_i, last_vertex_i);
    end
    errors_o  <= errors;
    pending_o <= pending_locations.size();
  end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
module tb;
  import pipc_pkg::*;

  localparam int QuietLimit = 3000;
  localparam int LongHold   = 200;
  localparam int NumItems   = 800;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic       operation_i;
  coord_t     coord_x_i;
  coord_t     coord_y_i;
  logic       last_vertex_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [1:0] location_o;
  int         errors;
  int         pending;

  int burst_left;
  int beats_sent;
  int quiet_cycles = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  point_in_polygon_classifier_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .operation_i   (operation_i),
    .coord_x_i     (coord_x_i),
    .coord_y_i     (coord_y_i),
    .last_vertex_i (last_vertex_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .location_o    (location_o)
  );

  pip_location_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .operation_i   (operation_i),
    .coord_x_i     (coord_x_i),
    .coord_y_i     (coord_y_i),
    .last_vertex_i (last_vertex_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .location_i    (location_o),
    .errors_o      (errors),
    .pending_o     (pending)
  );

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QuietLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic coord_t rand_coord(int kind);
    int v;
    if (kind <= 2 && $urandom_range(0, 15) != 0) begin
      v = $urandom_range(0, 16);
      return coord_t'(v - 8);
    end
    if (kind == 5) begin
      case ($urandom_range(0, 6))
        0: return coord_t'(-32768);
        1: return coord_t'(-32767);
        2: return coord_t'(-1);
        3: return coord_t'(0);
        4: return coord_t'(1);
        5: return coord_t'(32766);
        default: return coord_t'(32767);
      endcase
    end
    return coord_t'($urandom());
  endfunction

  task automatic send_beat(op_e op, coord_t x, coord_t y, logic last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid_i    <= 1'b1;
    operation_i   <= op;
    coord_x_i     <= x;
    coord_y_i     <= y;
    last_vertex_i <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    burst_left--;
    beats_sent++;
  endtask

  task automatic send_random_polygon();
    int n;
    int kind;
    kind = $urandom_range(0, 5);
    if ($urandom_range(0, 9) < 7)
      send_beat(OpLoadQuery, rand_coord(kind), rand_coord(kind), 1'($urandom_range(0, 1)));
    n = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 8);
    for (int i = 1; i <= n; i++) begin
      // a query load in the middle of a polygon throws it away
      if ($urandom_range(0, 24) == 0)
        send_beat(OpLoadQuery, rand_coord(kind), rand_coord(kind), 1'($urandom_range(0, 1)));
      send_beat(OpVertex, rand_coord(kind), rand_coord(kind), i == n);
    end
  endtask

  initial begin : receiver
    int  mode;
    int  span;
    int  cyc;
    bit  held;
    out_stall_i <= 1'b0;
    held = 1'b0;
    cyc  = 0;
    wait (rst_ni === 1'b1);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(5, 60);
      repeat (span) begin
        @(posedge clk_i);
        cyc++;
        // one long hold so the block backs up into its input
        if (!held && cyc >= 300) begin
          held = 1'b1;
          out_stall_i <= 1'b1;
          repeat (LongHold) @(posedge clk_i);
        end
        case (mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(0, 3) == 0);
          2: out_stall_i <= $urandom_range(0, 1);
          default: out_stall_i <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    rst_ni        <= 1'b0;
    in_valid_i    <= 1'b0;
    operation_i   <= OpLoadQuery;
    coord_x_i     <= '0;
    coord_y_i     <= '0;
    last_vertex_i <= 1'b0;
    burst_left   = 0;
    beats_sent   = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // vertices before any query load use the reset point
    send_beat(OpVertex, -16'sd10, -16'sd10, 1'b0);
    send_beat(OpVertex, 16'sd10, -16'sd10, 1'b0);
    send_beat(OpVertex, 16'sd10, 16'sd10, 1'b0);
    send_beat(OpVertex, -16'sd10, 16'sd10, 1'b1);
    // last flag on a query load is ignored
    send_beat(OpLoadQuery, coord_t'(32767), coord_t'(-32768), 1'b1);
    // single-vertex polygons, on the point and off it
    send_beat(OpVertex, coord_t'(32767), coord_t'(-32768), 1'b1);
    send_beat(OpVertex, coord_t'(-32768), coord_t'(32767), 1'b1);
    // full-range triangle
    send_beat(OpLoadQuery, 16'sd0, 16'sd0, 1'b0);
    send_beat(OpVertex, coord_t'(-32768), coord_t'(-32768), 1'b0);
    send_beat(OpVertex, coord_t'(32767), coord_t'(-32768), 1'b0);
    send_beat(OpVertex, 16'sd0, coord_t'(32767), 1'b1);
    // point on a horizontal edge
    send_beat(OpLoadQuery, 16'sd5, 16'sd0, 1'b0);
    send_beat(OpVertex, 16'sd0, 16'sd0, 1'b0);
    send_beat(OpVertex, 16'sd10, 16'sd0, 1'b0);
    send_beat(OpVertex, 16'sd10, 16'sd10, 1'b0);
    send_beat(OpVertex, 16'sd0, 16'sd10, 1'b1);
    // query kept after a result
    send_beat(OpVertex, 16'sd20, -16'sd5, 1'b0);
    send_beat(OpVertex, 16'sd30, -16'sd5, 1'b0);
    send_beat(OpVertex, 16'sd30, 16'sd5, 1'b1);
    // ray through a vertex
    send_beat(OpLoadQuery, 16'sd20, 16'sd10, 1'b0);
    send_beat(OpVertex, 16'sd0, 16'sd0, 1'b0);
    send_beat(OpVertex, 16'sd10, 16'sd10, 1'b0);
    send_beat(OpVertex, 16'sd0, 16'sd20, 1'b1);

    while (beats_sent < NumItems) send_random_polygon();
    in_valid_i <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (errors == 0 && pending == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
